// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lpfd_pkg.sv =====
`default_nettype none
package lpfd_pkg;

	// Header size in bytes; the length field counts itself
	localparam int unsigned HDR_BYTES = 2;

	// Reset value of the maximum payload register
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1514;

	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Parser phase
	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_PASS = 2'd2,
		PH_DROP = 2'd3
	} phase_t;

	// Result kind
	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_DROP   = 2'd1,
		KIND_LENERR = 2'd2,
		KIND_EMPTY  = 2'd3
	} kind_t;

	// One queued result word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} rslt_t;

	// Queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// ===== hdl/lpfd_in_if.sv =====
`default_nettype none
interface lpfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       burst_last;

	modport source (output valid, output data_byte, output burst_last, input ready);
	modport sink   (input valid, input data_byte, input burst_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/lpfd_out_if.sv =====
`default_nettype none
interface lpfd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload;
	logic       frame_last;

	modport source (output valid, output kind, output payload, output frame_last, input ready);
	modport sink   (input valid, input kind, input payload, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/lpfd_cfg_if.sv =====
`default_nettype none
interface lpfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/length_prefixed_frame_deframer.sv =====
// Length-prefixed frame deframer. Each frame on rx starts with a 16-bit big-endian
// length that includes its own two bytes; the payload bytes come out on tx one per
// word with frame_last set on the final one. Frames longer than max_payload give one
// oversize report on tx and are consumed silently, a length of exactly two gives one
// empty-frame report, and a length below two gives one length-error report after
// which the rest of the current burst (up to burst_last) is discarded. The block
// takes one rx word per clock: the parser updates a single counter per byte, and a
// two-entry queue plus the tx output register keep rx flowing while tx stalls, so
// rx.ready drops only once both are full. A result passes through the queue and
// then the tx output register. max_payload is written through cfg, which is always
// ready, and resets to 1514.
`default_nettype none
module length_prefixed_frame_deframer (
	input  wire        clk,
	input  wire        arst_n,
	lpfd_in_if.sink    rx,
	lpfd_cfg_if.sink   cfg,
	lpfd_out_if.source tx
);
	import lpfd_pkg::*;

	q_status_t q_status;
	logic      push;
	rslt_t     push_word;
	logic      pop;
	rslt_t     pop_word;

	lpfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.q_status  (q_status),
		.push      (push),
		.push_word (push_word)
	);

	lpfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.status    (q_status)
	);

	lpfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop_word (pop_word),
		.pop      (pop),
		.tx       (tx)
	);

endmodule
`default_nettype wire

// ===== hdl/lpfd_front.sv =====
`default_nettype none
module lpfd_front (
	input  wire                   clk,
	input  wire                   arst_n,
	lpfd_in_if.sink               rx,
	lpfd_cfg_if.sink              cfg,
	input  lpfd_pkg::q_status_t   q_status,
	output logic                  push,
	output lpfd_pkg::rslt_t       push_word
);
	import lpfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] left_q, left_d;
	logic        skip_q, skip_d;
	logic [15:0] max_pay_q;

	logic        acc;
	logic [15:0] len;
	logic [15:0] pay;
	logic [15:0] left_dec;

	// Register write channel never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pay_q <= MAX_PAYLOAD_RST;
		end else if (cfg.valid) begin
			max_pay_q <= cfg.data;
		end
	end

	// Take a word whenever the queue has room
	assign rx.ready = !q_status.full;
	assign acc      = rx.valid && rx.ready;

	assign len      = {len_hi_q, rx.data_byte};
	assign pay      = len - 16'(HDR_BYTES);
	assign left_dec = (left_q != 16'd0) ? (left_q - 16'd1) : left_q;

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HIGH;
			left_q  <= '0;
			skip_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			skip_q  <= skip_d;
		end
	end

	always_ff @(posedge clk) begin
		len_hi_q <= len_hi_d;
	end

	// Classify each accepted word and queue any result it yields
	always_comb begin
		phase_d   = phase_q;
		len_hi_d  = len_hi_q;
		left_d    = left_q;
		skip_d    = skip_q;
		push      = 1'b0;
		push_word = '{kind: KIND_DATA, data: rx.data_byte, last: 1'b1};
		if (acc) begin
			if (skip_q) begin
				// Discard up to the end of the burst
				if (rx.burst_last) begin
					skip_d  = 1'b0;
					phase_d = PH_HIGH;
				end
			end else begin
				case (phase_q)
					PH_HIGH: begin
						len_hi_d = rx.data_byte;
						phase_d  = PH_LOW;
					end
					PH_LOW: begin
						phase_d = PH_HIGH;
						push    = 1'b1;
						if (len < 16'(HDR_BYTES)) begin
							skip_d         = !rx.burst_last;
							push_word.kind = KIND_LENERR;
						end else if (pay == 16'd0) begin
							push_word.kind = KIND_EMPTY;
						end else begin
							left_d = pay;
							if (pay > max_pay_q) begin
								phase_d        = PH_DROP;
								push_word.kind = KIND_DROP;
							end else begin
								phase_d = PH_PASS;
								push    = 1'b0;
							end
						end
					end
					PH_PASS: begin
						left_d         = left_dec;
						push           = 1'b1;
						push_word.last = (left_dec == 16'd0);
						if (left_dec == 16'd0) begin
							phase_d = PH_HIGH;
						end
					end
					PH_DROP: begin
						left_d = left_dec;
						if (left_dec == 16'd0) begin
							phase_d = PH_HIGH;
						end
					end
					default: begin
						phase_d = PH_HIGH;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpfd_queue.sv =====
`default_nettype none
module lpfd_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  lpfd_pkg::rslt_t       push_word,
	input  wire                   pop,
	output lpfd_pkg::rslt_t       pop_word,
	output lpfd_pkg::q_status_t   status
);
	import lpfd_pkg::*;

	rslt_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_word     = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (do_pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_word;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpfd_back.sv =====
`default_nettype none
module lpfd_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lpfd_pkg::q_status_t   q_status,
	input  lpfd_pkg::rslt_t       pop_word,
	output logic                  pop,
	lpfd_out_if.source            tx
);
	import lpfd_pkg::*;

	logic       out_vld_q;
	logic [1:0] kind_q;
	logic [7:0] payload_q;
	logic       last_q;

	// Refill the output register when it is empty or being taken
	assign pop = !q_status.empty && (!out_vld_q || tx.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || tx.ready) begin
			out_vld_q <= !q_status.empty;
		end
	end

	// Load result fields; reports carry no byte
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= pop_word.kind;
			payload_q <= (pop_word.kind == KIND_DATA) ? pop_word.data : 8'd0;
			last_q    <= pop_word.last;
		end
	end

	assign tx.valid      = out_vld_q;
	assign tx.kind       = kind_q;
	assign tx.payload    = payload_q;
	assign tx.frame_last = last_q;

endmodule
`default_nettype wire

// ===== hdl/lpfd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module lpfd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       tx_valid,
	input wire       tx_ready,
	input wire [1:0] tx_kind,
	input wire [7:0] tx_payload,
	input wire       tx_frame_last
);
	import lpfd_pkg::*;

	// A stalled word stays offered
	`AST_NEXT(a_tx_hold, clk, arst_n, tx_valid && !tx_ready, tx_valid, "tx valid dropped while stalled")

	// A stalled word keeps its fields
	`AST_NEXT(a_tx_stable, clk, arst_n, tx_valid && !tx_ready, $stable({tx_kind, tx_payload, tx_frame_last}), "tx word changed while stalled")

	// Every report closes its frame
	`AST_IMPL(a_rpt_last, clk, arst_n, tx_valid && (tx_kind != KIND_DATA), tx_frame_last, "report without frame_last")

	// Reports carry no byte
	`AST_IMPL(a_rpt_zero, clk, arst_n, tx_valid && (tx_kind != KIND_DATA), tx_payload == 8'd0, "report with nonzero payload")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (tx.valid),
	.tx_ready      (tx.ready),
	.tx_kind       (tx.kind),
	.tx_payload    (tx.payload),
	.tx_frame_last (tx.frame_last)
);
`default_nettype wire
